// File: hdl/owo_pkg.sv
package owo_pkg;

  // shared multiplier operand and product widths
  localparam int MA_W = 35;
  localparam int MB_W = 33;
  localparam int PW   = 68;
  // divider denominator width
  localparam int DEN_W = 33;
  localparam int CORDIC_STEPS = 30;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam longint PI_Q30_L     = 64'sd3373259426;
  localparam longint TWO_PI_Q30_L = 64'sd6746518852;
  // sqrt(2)/4 in Q0.30
  localparam logic signed [MB_W-1:0] K_SQRT2_4 = 33'sd379625062;

  localparam logic [1:0] CFG_WHEEL_SPACING = 2'd0;
  localparam logic [1:0] CFG_SPEED_SCALE   = 2'd1;
  localparam logic [1:0] CFG_SIGN_MASK     = 2'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE    = 2'd0,
    OP_INTEGRATE = 2'd1,
    OP_AVERAGE   = 2'd2,
    OP_LOAD      = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_WMUL, S_WFIX, S_VX, S_VXF, S_VY, S_VYF, S_YAW, S_YAWW, S_ACC,
    S_IMUL, S_IMID, S_WRAP, S_WRAPW, S_WRAPR, S_WRAPC, S_WRAPD, S_COR, S_CORW,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
    S_AVG, S_AVGW, S_OUT
  } state_e;

  function automatic logic [29:0] atan_f(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837830;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      default: r = 30'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic logic signed [PW-1:0] rshr(input logic signed [PW-1:0] v,
                                                input int s);
    logic signed [PW-1:0] half;
    half = '0;
    half[s-1] = 1'b1;
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] mx;
    logic signed [PW-1:0] mn;
    mx = PW'(64'sd2147483647);
    mn = -mx - PW'(64'sd1);
    if (v > mx) return 32'sh7FFF_FFFF;
    if (v < mn) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    logic signed [40:0] mx;
    logic signed [40:0] mn;
    mx = 41'sd549755813887;
    mn = -mx - 41'sd1;
    if (v > mx) return 40'sh7F_FFFF_FFFF;
    if (v < mn) return 40'sh80_0000_0000;
    return v[39:0];
  endfunction

endpackage

// File: hdl/owo_div.sv
module owo_div import owo_pkg::*; #(
  parameter int NUM_W = 50
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             take;

  // one restoring step per cycle
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    take  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], take};
      rem_q <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: hdl/owo_cordic.sv
module owo_cordic import owo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [33:0] angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic               busy_q;
  logic               done_q;
  logic [4:0]         step_q;
  logic               flip_q;
  logic signed [32:0] x_q, x_d;
  logic signed [32:0] y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic signed [32:0] dx, dy;
  logic signed [33:0] at;
  logic signed [33:0] fold_z;
  logic               fold_flip;

  // fold into plus or minus pi/2, undone by negating the result
  always_comb begin
    fold_z    = angle_i;
    fold_flip = 1'b0;
    if (angle_i > HALF_PI_Q30) begin
      fold_z    = angle_i - PI_Q30;
      fold_flip = 1'b1;
    end else if (angle_i < -HALF_PI_Q30) begin
      fold_z    = angle_i + PI_Q30;
      fold_flip = 1'b1;
    end
  end

  always_comb begin
    dx = y_q >>> step_q;
    dy = x_q >>> step_q;
    at = signed'({4'b0, atan_f(step_q)});
    if (z_q >= 0) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - at;
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 5'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= 33'(CORDIC_GAIN);
      y_q    <= '0;
      z_q    <= fold_z;
      flip_q <= fold_flip;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? 32'(-x_q) : 32'(x_q);
  assign sin_o  = flip_q ? 32'(-y_q) : 32'(y_q);

endmodule

// File: hdl/omni_wheel_odometry.sv
// Odometry for a four-wheel omni drive, signed fixed point with FRAC_BITS fraction.
// Input channel (in_valid_i / in_stall_o) carries one request: op plus all its fields;
// a request is taken when valid is high and stall is low. Output channel
// (out_valid_o / out_stall_i) returns one result per request: wheel speeds, control
// speeds and pose after the request. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write it only while no request is in
// flight, which the block itself does not enforce. Work is sequenced over one
// registered multiplier, a radix-2 divider over NUM_W = 34 + FRAC_BITS quotient
// bits, and a 30-step CORDIC; heading wraps use a reciprocal multiply on the
// shared multiplier. An rpm sample ends in the yaw division; integrate runs the
// CORDIC and each heading wrap that is needed; average runs seven divisions, or
// none when the count is 0; set pose goes straight to the output step.
// in_stall_o is high from acceptance until the result is placed in the output
// register; a new request can be taken while that result still waits. If the
// receiver stalls, the finished result holds and the next request waits in its
// last step. Reset clears all speeds, sums and pose and loads the default registers.
module omni_wheel_odometry import owo_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [15:0] rpm_0_i,
  input  logic signed [15:0] rpm_1_i,
  input  logic signed [15:0] rpm_2_i,
  input  logic signed [15:0] rpm_3_i,
  input  logic [15:0]        step_time_i,
  input  logic [7:0]         sample_count_i,
  input  logic signed [31:0] load_x_i,
  input  logic signed [31:0] load_y_i,
  input  logic signed [18:0] load_heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] wheel_speed_0_o,
  output logic signed [31:0] wheel_speed_1_o,
  output logic signed [31:0] wheel_speed_2_o,
  output logic signed [31:0] wheel_speed_3_o,
  output logic signed [31:0] control_vx_o,
  output logic signed [31:0] control_vy_o,
  output logic signed [31:0] control_yaw_rate_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [18:0] heading_o
);

  localparam int NUM_W  = 34 + FRAC_BITS;
  localparam int ANG_SH = 30 - FRAC_BITS;
  localparam longint PI_F =
      (PI_Q30_L + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam longint TWO_PI_F =
      (TWO_PI_Q30_L + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam logic signed [33:0] PI_F_S     = 34'(PI_F);
  localparam logic signed [33:0] WRAP_BIAS  = 34'(TWO_PI_F - 1);
  localparam logic signed [33:0] WRAP_OFS   = 34'(TWO_PI_F - PI_F - 1);
  localparam logic signed [33:0] TWO_PI_S   = 34'(TWO_PI_F);
  localparam logic signed [MB_W-1:0] TWO_PI_M = MB_W'(TWO_PI_F);
  // floor(2^RCP_SH / 2pi) estimates the wrap count low by at most one
  localparam int RCP_SH = 31 + $clog2(TWO_PI_F);
  localparam logic [31:0] RCP_M = 32'((longint'(1) <<< RCP_SH) / TWO_PI_F);

  state_e state_q, state_d;

  logic [30:0] ws_q;
  logic [31:0] scale_q;
  logic [3:0]  mask_q;

  // speeds: wheels 0..3, control vx, vy, yaw 4..6; sums in the same order
  logic signed [31:0] spd_q [7];
  logic signed [39:0] sum_q [7];
  logic signed [31:0] inst_q [3];
  logic signed [31:0] pos_x_q, pos_y_q, hdg_q;

  logic signed [15:0] rpm_q [4];
  logic [15:0]        dt_q;
  logic [7:0]         cnt_n_q;
  logic [2:0]         idx_q;
  logic               phase_q;
  logic               negq_q;
  logic               wrap_hi_q;
  logic signed [PW-1:0] acc_q;
  logic signed [33:0] m_q;
  logic signed [33:0] dth_q;
  logic signed [33:0] t_q;
  logic signed [33:0] wn_q;
  logic signed [33:0] wr_q;

  logic               out_valid_q;
  logic signed [31:0] o_spd_q [7];
  logic signed [31:0] o_px_q, o_py_q;
  logic signed [18:0] o_hdg_q;

  logic                  in_acc;
  logic                  out_load;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PW-1:0]   mul_q;

  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  logic               cor_start;
  logic               cor_done;
  logic signed [31:0] cor_cos, cor_sin;

  logic signed [MA_W-1:0] w0, w1, w2, w3;
  logic signed [MA_W-1:0] vx_sum, vy_sum, yaw_sum, yaw_mag;
  logic [DEN_W-1:0]       yaw_den;
  logic signed [40:0]     avg_mag;
  logic signed [31:0]     wfix_raw, wfix;
  logic signed [PW-1:0]   quo_x, quo_s;
  logic signed [31:0]     quo_sat;
  logic signed [33:0]     wrap_num, wrem, wrap_res;
  logic                   t_hi, t_lo;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_OUT) && !(out_valid_q && out_stall_i);

  always_comb begin
    w0      = MA_W'(spd_q[0]);
    w1      = MA_W'(spd_q[1]);
    w2      = MA_W'(spd_q[2]);
    w3      = MA_W'(spd_q[3]);
    vx_sum  = -w0 + w1 + w2 - w3;
    vy_sum  = w0 + w1 - w2 - w3;
    yaw_sum = w0 + w1 + w2 + w3;
    yaw_mag = (yaw_sum < 0) ? -yaw_sum : yaw_sum;
    yaw_den = {ws_q, 2'b00};
    avg_mag = (sum_q[idx_q] < 0) ? -41'(sum_q[idx_q]) : 41'(sum_q[idx_q]);
    wfix_raw = sat32(rshr(mul_q, 32 - FRAC_BITS));
    wfix     = mask_q[idx_q[1:0]] ? sat32(-PW'(wfix_raw)) : wfix_raw;
    quo_x    = signed'({{(PW - NUM_W){1'b0}}, div_quo});
    quo_s    = negq_q ? -quo_x : quo_x;
    quo_sat  = sat32(quo_s);
    t_hi     = t_q > PI_F_S;
    t_lo     = t_q < -PI_F_S;
    wrap_num = t_hi ? (t_q - PI_F_S + WRAP_BIAS) : (-PI_F_S - t_q + WRAP_BIAS);
    wrem     = (wr_q >= TWO_PI_S) ? (wr_q - TWO_PI_S) : wr_q;
    wrap_res = wrap_hi_q ? (wrem - WRAP_OFS) : (WRAP_OFS - wrem);
  end

  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    cor_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_e'(op_i))
            OP_SAMPLE:    state_d = S_WMUL;
            OP_INTEGRATE: state_d = S_IMUL;
            OP_AVERAGE:   state_d = (sample_count_i == 8'd0) ? S_OUT : S_AVG;
            OP_LOAD:      state_d = S_OUT;
            default:      state_d = S_OUT;
          endcase
        end
      end
      S_WMUL: begin
        mul_a   = MA_W'(rpm_q[idx_q[1:0]]);
        mul_b   = signed'({1'b0, scale_q});
        state_d = S_WFIX;
      end
      S_WFIX: state_d = (idx_q == 3'd3) ? S_VX : S_WMUL;
      S_VX: begin
        mul_a   = vx_sum;
        mul_b   = K_SQRT2_4;
        state_d = S_VXF;
      end
      S_VXF: state_d = S_VY;
      S_VY: begin
        mul_a   = vy_sum;
        mul_b   = K_SQRT2_4;
        state_d = S_VYF;
      end
      S_VYF: state_d = S_YAW;
      S_YAW: begin
        div_start = 1'b1;
        div_num   = (NUM_W'(yaw_mag) << FRAC_BITS) + NUM_W'(yaw_den >> 1);
        div_den   = yaw_den;
        state_d   = S_YAWW;
      end
      S_YAWW: if (div_done) state_d = S_ACC;
      S_ACC:  state_d = S_OUT;
      S_IMUL: begin
        mul_a   = MA_W'(inst_q[2]);
        mul_b   = signed'({17'b0, dt_q});
        state_d = S_IMID;
      end
      S_IMID: state_d = S_WRAP;
      S_WRAP: begin
        if (t_hi || t_lo) begin
          mul_a   = MA_W'(wrap_num);
          mul_b   = signed'({1'b0, RCP_M});
          state_d = S_WRAPW;
        end else begin
          state_d = S_WRAPD;
        end
      end
      // estimated wrap count times 2pi
      S_WRAPW: begin
        mul_a   = MA_W'(mul_q >>> RCP_SH);
        mul_b   = TWO_PI_M;
        state_d = S_WRAPR;
      end
      S_WRAPR: state_d = S_WRAPC;
      S_WRAPC: state_d = S_WRAPD;
      S_WRAPD: state_d = phase_q ? S_OUT : S_COR;
      S_COR: begin
        cor_start = 1'b1;
        state_d   = S_CORW;
      end
      S_CORW: if (cor_done) state_d = S_P1;
      S_P1: begin
        mul_a   = MA_W'(inst_q[0]);
        mul_b   = MB_W'(cor_cos);
        state_d = S_P2;
      end
      S_P2: begin
        mul_a   = MA_W'(inst_q[1]);
        mul_b   = MB_W'(cor_sin);
        state_d = S_P3;
      end
      S_P3: state_d = S_P4;
      S_P4: begin
        mul_a   = MA_W'(m_q);
        mul_b   = signed'({17'b0, dt_q});
        state_d = S_P5;
      end
      S_P5: begin
        mul_a   = MA_W'(inst_q[0]);
        mul_b   = MB_W'(cor_sin);
        state_d = S_P6;
      end
      S_P6: begin
        mul_a   = MA_W'(inst_q[1]);
        mul_b   = MB_W'(cor_cos);
        state_d = S_P7;
      end
      S_P7: state_d = S_P8;
      S_P8: begin
        mul_a   = MA_W'(m_q);
        mul_b   = signed'({17'b0, dt_q});
        state_d = S_P9;
      end
      S_P9: state_d = S_WRAP;
      S_AVG: begin
        div_start = 1'b1;
        div_num   = NUM_W'(avg_mag) + NUM_W'(cnt_n_q >> 1);
        div_den   = DEN_W'(cnt_n_q);
        state_d   = S_AVGW;
      end
      S_AVGW: if (div_done) state_d = (idx_q == 3'd6) ? S_OUT : S_AVG;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q    <= 31'd13107;
      scale_q <= 32'd13493037;
      mask_q  <= '0;
      for (int i = 0; i < 7; i++) begin
        spd_q[i] <= '0;
        sum_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) inst_q[i] <= '0;
      pos_x_q <= '0;
      pos_y_q <= '0;
      hdg_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WHEEL_SPACING: if (cfg_data_i[30:0] != 31'd0) ws_q <= cfg_data_i[30:0];
          CFG_SPEED_SCALE:   scale_q <= cfg_data_i;
          CFG_SIGN_MASK:     mask_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_acc && (op_e'(op_i) == OP_LOAD)) begin
        pos_x_q <= load_x_i;
        pos_y_q <= load_y_i;
        hdg_q   <= 32'(load_heading_i);
      end
      case (state_q)
        S_WFIX: spd_q[idx_q] <= wfix;
        S_VXF:  inst_q[0] <= sat32(rshr(mul_q, 30));
        S_VYF:  inst_q[1] <= sat32(rshr(mul_q, 30));
        S_YAWW: if (div_done) inst_q[2] <= quo_sat;
        S_ACC: begin
          for (int i = 0; i < 3; i++) begin
            spd_q[4+i] <= inst_q[i];
            sum_q[4+i] <= sat40(41'(sum_q[4+i]) + 41'(inst_q[i]));
          end
          for (int i = 0; i < 4; i++) begin
            sum_q[i] <= sat40(41'(sum_q[i]) + 41'(spd_q[i]));
          end
        end
        S_P5: pos_x_q <= sat32(PW'(pos_x_q) + rshr(mul_q, 16));
        S_P9: pos_y_q <= sat32(PW'(pos_y_q) + rshr(mul_q, 16));
        S_WRAPD: if (phase_q) hdg_q <= t_q[31:0];
        S_AVGW: begin
          if (div_done) begin
            spd_q[idx_q] <= quo_sat;
            if (idx_q == 3'd6) begin
              for (int i = 0; i < 7; i++) sum_q[i] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // request fields and scratch values
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rpm_q[0] <= rpm_0_i;
      rpm_q[1] <= rpm_1_i;
      rpm_q[2] <= rpm_2_i;
      rpm_q[3] <= rpm_3_i;
      dt_q     <= step_time_i;
      cnt_n_q  <= sample_count_i;
      idx_q    <= '0;
    end
    case (state_q)
      S_WFIX: idx_q <= idx_q + 3'd1;
      S_YAW:  negq_q <= yaw_sum > 0;
      S_IMID: begin
        t_q     <= 34'(hdg_q) + 34'(rshr(mul_q, 17));
        dth_q   <= 34'(rshr(mul_q, 16));
        phase_q <= 1'b0;
      end
      S_WRAP: begin
        wrap_hi_q <= t_hi;
        wn_q      <= wrap_num;
      end
      S_WRAPR: wr_q <= wn_q - 34'(mul_q);
      S_WRAPC: t_q <= wrap_res;
      S_P2: acc_q <= mul_q;
      S_P3: m_q <= 34'(rshr(acc_q - mul_q, 30));
      S_P6: acc_q <= mul_q;
      S_P7: m_q <= 34'(rshr(acc_q + mul_q, 30));
      S_P9: begin
        t_q     <= 34'(hdg_q) + dth_q;
        phase_q <= 1'b1;
      end
      S_AVG: negq_q <= sum_q[idx_q] < 0;
      S_AVGW: if (div_done) idx_q <= idx_q + 3'd1;
      default: ;
    endcase
  end

  owo_div #(
    .NUM_W(NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  owo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (t_q <<< ANG_SH),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int i = 0; i < 7; i++) o_spd_q[i] <= spd_q[i];
      o_px_q  <= pos_x_q;
      o_py_q  <= pos_y_q;
      o_hdg_q <= hdg_q[18:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign wheel_speed_0_o    = o_spd_q[0];
  assign wheel_speed_1_o    = o_spd_q[1];
  assign wheel_speed_2_o    = o_spd_q[2];
  assign wheel_speed_3_o    = o_spd_q[3];
  assign control_vx_o       = o_spd_q[4];
  assign control_vy_o       = o_spd_q[5];
  assign control_yaw_rate_o = o_spd_q[6];
  assign pos_x_o            = o_px_q;
  assign pos_y_o            = o_py_q;
  assign heading_o          = o_hdg_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted request left the sequencer idle");

  a_div_done_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_YAWW || state_q == S_AVGW))
    else $error("divider finished outside a divide wait step");

  a_cordic_done_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> state_q == S_CORW)
    else $error("cordic finished outside its wait step");

  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == S_IDLE)
    else $error("result not posted after final step");

endmodule
